[hdl/srms_pkg.sv]
package srms_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned CELLS = 64;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } cell_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

[hdl/stable_run_merge_sorter.sv]
// Channel | Signals                                        | Direction
// input   | in_valid, in_ready, key, tag, last             | in
// output  | out_valid, out_ready, sorted_key, sorted_tag,  | out
//         | end_of_set, overflow                           |
// Loading takes one element per cycle; each cell of the chain compares in parallel.
// After the element marked last, the set drains from the head cell, one per cycle while out_ready is high.
// A whole set is loaded before it drains; no input is taken while draining.
// Reset empties the chain and clears the overflow flag.
// A stalled output holds the chain unchanged.
module stable_run_merge_sorter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] key,
  input  logic [15:0] tag,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sorted_key,
  output logic [15:0] sorted_tag,
  output logic        end_of_set,
  output logic        overflow
);

  srms_pkg::state_t state;
  srms_pkg::state_t state_next;
  srms_pkg::ctrl_t  ctrl;
  logic             dropped;
  logic             dropped_next;
  logic             full;
  logic             in_xfer;
  logic             out_xfer;

  srms_pkg::cell_t cells     [srms_pkg::CELLS];
  srms_pkg::cell_t prev_cell [srms_pkg::CELLS];
  srms_pkg::cell_t next_cell [srms_pkg::CELLS];
  logic            gts       [srms_pkg::CELLS];
  logic            prev_gt   [srms_pkg::CELLS];

  assign full     = cells[srms_pkg::CELLS-1].valid;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  genvar i;
  generate
    for (i = 0; i < srms_pkg::CELLS; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign prev_cell[i] = '{valid: 1'b1, key: '0, tag: '0};
        assign prev_gt[i]   = 1'b0;
      end else begin : g_body
        assign prev_cell[i] = cells[i-1];
        assign prev_gt[i]   = gts[i-1];
      end
      if (i == srms_pkg::CELLS - 1) begin : g_tail
        assign next_cell[i] = '{valid: 1'b0, key: '0, tag: '0};
      end else begin : g_inner
        assign next_cell[i] = cells[i+1];
      end
      srms_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .new_key   (key[srms_pkg::KEY_W-1:0]),
        .new_tag   (tag[srms_pkg::TAG_W-1:0]),
        .prev_cell (prev_cell[i]),
        .prev_gt   (prev_gt[i]),
        .next_cell (next_cell[i]),
        .held      (cells[i]),
        .gt        (gts[i])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    unique case (state)
      srms_pkg::ST_LOAD: begin
        if (in_xfer && last) begin
          state_next = srms_pkg::ST_DRAIN;
        end
      end
      srms_pkg::ST_DRAIN: begin
        if (out_xfer && end_of_set) begin
          state_next = srms_pkg::ST_LOAD;
        end
      end
      default: state_next = srms_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      srms_pkg::ST_LOAD:  in_ready  = 1'b1;
      srms_pkg::ST_DRAIN: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign ctrl = '{ins: in_xfer && !full, pop: out_xfer};

  always_comb begin
    dropped_next = dropped;
    if (out_xfer && end_of_set) begin
      dropped_next = 1'b0;
    end else if (in_xfer && full) begin
      dropped_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= srms_pkg::ST_LOAD;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

  assign sorted_key = cells[0].key;
  assign sorted_tag = cells[0].tag;
  assign end_of_set = !cells[1].valid;
  assign overflow   = dropped;

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_drain_head: assert property (@(posedge clk) disable iff (rst) out_valid |-> cells[0].valid)
    else $error("draining from an empty head cell");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && end_of_set) |=> (in_ready && !cells[0].valid && !overflow))
    else $error("chain not empty after the final transfer of a set");

  a_drain_goes_on: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && !end_of_set) |=> (out_valid && $stable(overflow)))
    else $error("set ended before its final element");

endmodule

[hdl/srms_cell.sv]
module srms_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  srms_pkg::ctrl_t           ctrl,
  input  logic [srms_pkg::KEY_W-1:0] new_key,
  input  logic [srms_pkg::TAG_W-1:0] new_tag,
  input  srms_pkg::cell_t           prev_cell,
  input  logic                      prev_gt,
  input  srms_pkg::cell_t           next_cell,
  output srms_pkg::cell_t           held,
  output logic                      gt
);

  logic                       valid;
  logic                       valid_next;
  logic [srms_pkg::KEY_W-1:0] key;
  logic [srms_pkg::KEY_W-1:0] key_next;
  logic [srms_pkg::TAG_W-1:0] tag;
  logic [srms_pkg::TAG_W-1:0] tag_next;

  // The new element goes behind every held element with an equal key.
  assign gt = valid && (key > new_key);

  always_comb begin
    valid_next = valid;
    key_next   = key;
    tag_next   = tag;
    if (ctrl.pop) begin
      valid_next = next_cell.valid;
      key_next   = next_cell.key;
      tag_next   = next_cell.tag;
    end else if (ctrl.ins) begin
      if (prev_gt) begin
        valid_next = prev_cell.valid;
        key_next   = prev_cell.key;
        tag_next   = prev_cell.tag;
      end else if (gt || (!valid && prev_cell.valid)) begin
        valid_next = 1'b1;
        key_next   = new_key;
        tag_next   = new_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    tag <= tag_next;
  end

  assign held = '{valid: valid, key: key, tag: tag};

endmodule

[test/tb_stable_run_merge_sorter.sv]
`timescale 1ns / 1ps

module tb_stable_run_merge_sorter;

  localparam int unsigned KEY_W = srms_pkg::KEY_W;
  localparam int unsigned TAG_W = srms_pkg::TAG_W;
  localparam int unsigned CELLS = srms_pkg::CELLS;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 2 * CELLS + 8;
  localparam int RANDOM_ITEMS = 20;

  typedef enum {
    KEYS_FULL,
    KEYS_FEW,
    KEYS_EXTREME
  } key_mode_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
  } element_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             eos;
    logic             ovf;
  } sorted_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [KEY_W-1:0] key = '0;
  logic [TAG_W-1:0] tag = '0;
  logic             last = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [KEY_W-1:0] sorted_key;
  logic [TAG_W-1:0] sorted_tag;
  logic             end_of_set;
  logic             overflow;

  element_t         pending_elements[$];
  sorted_t          sorted_expect[$];
  logic [KEY_W-1:0] stored_keys[CELLS];
  logic [TAG_W-1:0] stored_tags[CELLS];
  int               stored_count = 0;
  logic             store_dropped = 1'b0;
  int               mismatches = 0;
  int               quiet_cycles = 0;
  logic             steady = 1'b0;
  logic             hold_go = 1'b0;
  logic             hold_off = 1'b0;

  stable_run_merge_sorter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .key       (key),
    .tag       (tag),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sorted_key(sorted_key),
    .sorted_tag(sorted_tag),
    .end_of_set(end_of_set),
    .overflow  (overflow)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  // Each element is inserted behind every held element with an equal key, so the
  // store stays sorted and stable; a full store drops the element.
  function automatic void absorb_element(input element_t e);
    int      slot;
    sorted_t r;
    if (stored_count < int'(CELLS)) begin
      slot = stored_count;
      while (slot > 0 && stored_keys[slot-1] > e.key) begin
        stored_keys[slot] = stored_keys[slot-1];
        stored_tags[slot] = stored_tags[slot-1];
        slot--;
      end
      stored_keys[slot] = e.key;
      stored_tags[slot] = e.tag;
      stored_count++;
    end else begin
      store_dropped = 1'b1;
    end
    if (e.last) begin
      for (int i = 0; i < stored_count; i++) begin
        r.key = stored_keys[i];
        r.tag = stored_tags[i];
        r.eos = (i == stored_count - 1);
        r.ovf = store_dropped;
        sorted_expect.push_back(r);
      end
      stored_count = 0;
      store_dropped = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : feed_elements
    element_t e;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        e.key = key;
        e.tag = tag;
        e.last = last;
        absorb_element(e);
      end
      if (!in_valid || in_ready) begin
        if (pending_elements.size() != 0 && (steady || $urandom_range(99) >= 17)) begin
          e = pending_elements.pop_front();
          in_valid <= 1'b1;
          key <= e.key;
          tag <= e.tag;
          last <= e.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    sorted_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sorted_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer key=%h tag=%h", sorted_key, sorted_tag));
        end else begin
          want = sorted_expect.pop_front();
          if (sorted_key !== want.key) begin
            report_mismatch($sformatf("sorted_key %h, want %h", sorted_key, want.key));
          end
          if (sorted_tag !== want.tag) begin
            report_mismatch($sformatf("sorted_tag %h, want %h", sorted_tag, want.tag));
          end
          if (end_of_set !== want.eos) begin
            report_mismatch($sformatf("end_of_set %b, want %b", end_of_set, want.eos));
          end
          if (overflow !== want.ovf) begin
            report_mismatch($sformatf("overflow %b, want %b", overflow, want.ovf));
          end
        end
      end
      out_ready <= !hold_off && (steady || $urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[stable_run_merge_sorter] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver stops taking transfers for a long stretch once asked to.
  initial begin : receiver_hold
    wait (hold_go);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  task automatic push_element(input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                              input logic l);
    element_t e;
    e.key = k;
    e.tag = t;
    e.last = l;
    pending_elements.push_back(e);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input key_mode_t mode);
    logic [KEY_W-1:0] k;
    case (mode)
      KEYS_FEW: begin
        k = KEY_W'($urandom_range(3, 0));
      end
      KEYS_EXTREME: begin
        case ($urandom_range(4, 0))
          0: k = '0;
          1: k = '1;
          2: k = KEY_W'(1);
          3: k = {1'b1, {(KEY_W-1){1'b0}}};
          default: k = {1'b0, {(KEY_W-1){1'b1}}};
        endcase
      end
      default: begin
        k = KEY_W'($urandom);
      end
    endcase
    return k;
  endfunction

  task automatic push_set(input int len, input key_mode_t mode);
    for (int i = 0; i < len; i++) begin
      push_element(pick_key(mode), TAG_W'($urandom), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_elements.size() != 0 || in_valid || sorted_expect.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin : stimulus
    int        random_count;
    int        len;
    key_mode_t mode;
    random_count = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_element('0, '0, 1'b1);
    push_element('1, '1, 1'b1);
    push_element(5, 1, 1'b0);
    push_element(3, 2, 1'b0);
    push_element(5, 3, 1'b0);
    push_element('1, 4, 1'b0);
    push_element(3, 5, 1'b0);
    push_element(0, 6, 1'b0);
    push_element(5, 7, 1'b1);
    push_element(40, 16'h00a0, 1'b0);
    push_element(30, 16'h00b0, 1'b0);
    push_element(20, 16'h00c0, 1'b0);
    push_element(10, 16'h00d0, 1'b1);
    push_element(1, 16'hffff, 1'b0);
    push_element(2, 16'h0000, 1'b0);
    push_element(3, 16'h8000, 1'b1);
    push_element(32'h8000_0000, 16'h5555, 1'b0);
    push_element(32'h7fff_ffff, 16'haaaa, 1'b1);
    wait_drained();

    // The store fills, the extra elements and the marked one are dropped, and
    // the stalled output backs up into the input while the next set waits.
    @(negedge clk);
    steady = 1'b1;
    hold_go = 1'b1;
    push_set(CELLS + 6, KEYS_FEW);
    push_set(3, KEYS_FULL);
    wait_drained();
    steady = 1'b0;

    while (random_count < RANDOM_ITEMS) begin
      steady = (random_count < RANDOM_ITEMS / 2);
      len = $urandom_range(12, 1);
      mode = key_mode_t'($urandom_range(2, 0));
      push_set(len, mode);
      random_count += len;
      if ($urandom_range(9, 0) == 0) begin
        wait_drained();
      end else begin
        while (pending_elements.size() > 8) @(negedge clk);
      end
    end
    steady = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("[stable_run_merge_sorter] OK");
    end else begin
      $display("[stable_run_merge_sorter] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/srms_pkg.sv
hdl/srms_cell.sv
hdl/stable_run_merge_sorter.sv
test/tb_stable_run_merge_sorter.sv
